[rtl/vprq_pkg.sv]
// Shared types and constants for the vector pair rotation quaternion block.
// Holds the payload structs, the case code enum and the fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vprq_pkg;

    // Field widths and fixed-point formats
    localparam int IN_WIDTH      = 16;
    localparam int OUT_WIDTH     = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int Q30_BITS      = 30;
    localparam int ROUND_SH      = Q30_BITS - OUT_FRAC_BITS;

    // One in Q1.30 and the near-parallel threshold (0.999999 in Q30)
    localparam logic [Q30_BITS:0]        ONE_Q30   = (Q30_BITS + 1)'(1) << Q30_BITS;
    localparam logic signed [Q30_BITS+1:0] DOT_LIMIT = 32'sd1073740750;

    // One in the output format
    localparam logic signed [OUT_WIDTH-1:0] ONE_OUT = OUT_WIDTH'(1) << OUT_FRAC_BITS;

    typedef enum logic [1:0] {
        CASE_GENERAL  = 2'd0,
        CASE_ALIGNED  = 2'd1,
        CASE_OPPOSITE = 2'd2,
        CASE_ZERO     = 2'd3
    } t_case;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] start_x;
        logic signed [IN_WIDTH-1:0] start_y;
        logic signed [IN_WIDTH-1:0] start_z;
        logic signed [IN_WIDTH-1:0] target_x;
        logic signed [IN_WIDTH-1:0] target_y;
        logic signed [IN_WIDTH-1:0] target_z;
    } t_vec_pair;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] quat_w;
        logic signed [OUT_WIDTH-1:0] quat_x;
        logic signed [OUT_WIDTH-1:0] quat_y;
        logic signed [OUT_WIDTH-1:0] quat_z;
        t_case                       case_code;
    } t_quat;

endpackage

`default_nettype wire

[rtl/vector_pair_rotation_quaternion.sv]
// Throughput: one beat per cycle while no result is parked in the skid; every stage is
// pipelined, and the two 32-step square roots, the 31-step dot divider, the 31-step
// half-angle roots and the axis dividers set the depth.
// A stalled output parks one result in a skid register, then freezes the pipeline.
// Reset (synchronous, active low) clears all valid bits and the skid; payload is not reset.
// Depends on vprq_pkg, vprq_isqrt_pipe and vprq_div_pipe.
`timescale 1ns / 1ps
`default_nettype none

module vector_pair_rotation_quaternion (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vprq_pkg::t_vec_pair i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vprq_pkg::t_quat     o_out_data
);

    import vprq_pkg::*;

    localparam int PROD_W   = 2 * IN_WIDTH;
    localparam int SUM_W    = PROD_W + 2;
    localparam int CRS_W    = PROD_W + 1;
    localparam int WIDE_W   = 2 * PROD_W;
    localparam int D_NUM_W  = PROD_W + Q30_BITS;
    localparam int D_Q_W    = Q30_BITS + 1;
    localparam int HA_RAD_W = 2 * (Q30_BITS + 1);
    localparam int HA_W     = HA_RAD_W / 2;
    localparam int AX_PRD_W = PROD_W + HA_W;
    localparam int AX_NUM_W = WIDE_W - ROUND_SH;
    localparam int AX_Q_W   = OUT_FRAC_BITS + 1;

    typedef struct packed {
        logic [PROD_W-1:0]      emag;
        logic                   eneg;
        logic [2:0][PROD_W-1:0] cmag;
        logic [2:0]             cneg;
        logic                   zero;
    } t_side_p;

    typedef struct packed {
        logic                   eneg;
        logic [PROD_W-1:0]      cnorm;
        logic [2:0][PROD_W-1:0] cmag;
        logic [2:0]             cneg;
        logic                   zero;
    } t_side_d;

    typedef struct packed {
        t_case                  code;
        logic [PROD_W-1:0]      cnorm;
        logic [2:0][PROD_W-1:0] cmag;
        logic [2:0]             cneg;
    } t_side_w;

    typedef struct packed {
        t_case                  code;
        logic [OUT_WIDTH-1:0]   wr;
        logic [2:0]             cneg;
    } t_side_x;

    logic en;
    logic r_skid_full;

    // Advance everything unless a result is parked
    assign en         = !r_skid_full;
    assign o_in_ready = en;

    // ---------------- stage 1: products ----------------
    // Inputs stay at most 32768 in magnitude, so no range reduction is needed
    logic signed [IN_WIDTH-1:0] a [3];
    logic signed [IN_WIDTH-1:0] b [3];
    logic signed [PROD_W-1:0]   r_aa [3];
    logic signed [PROD_W-1:0]   r_bb [3];
    logic signed [PROD_W-1:0]   r_ab [3];
    logic signed [PROD_W-1:0]   r_xa [3];
    logic signed [PROD_W-1:0]   r_xb [3];
    logic                       r_v1;

    assign a[0] = i_in_data.start_x;
    assign a[1] = i_in_data.start_y;
    assign a[2] = i_in_data.start_z;
    assign b[0] = i_in_data.target_x;
    assign b[1] = i_in_data.target_y;
    assign b[2] = i_in_data.target_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_aa[i] <= PROD_W'(a[i] * a[i]);
                r_bb[i] <= PROD_W'(b[i] * b[i]);
                r_ab[i] <= PROD_W'(a[i] * b[i]);
            end
            r_xa[0] <= PROD_W'(a[1] * b[2]);
            r_xb[0] <= PROD_W'(a[2] * b[1]);
            r_xa[1] <= PROD_W'(a[2] * b[0]);
            r_xb[1] <= PROD_W'(a[0] * b[2]);
            r_xa[2] <= PROD_W'(a[0] * b[1]);
            r_xb[2] <= PROD_W'(a[1] * b[0]);
        end
    end

    // ---------------- stage 2: sums ----------------
    logic signed [SUM_W-1:0] s2_na;
    logic signed [SUM_W-1:0] s2_nb;
    logic [PROD_W-1:0]       r_na;
    logic [PROD_W-1:0]       r_nb;
    logic signed [SUM_W-1:0] r_e;
    logic signed [CRS_W-1:0] r_c [3];
    logic                    r_v2;

    always_comb begin
        s2_na = SUM_W'(r_aa[0]) + SUM_W'(r_aa[1]) + SUM_W'(r_aa[2]);
        s2_nb = SUM_W'(r_bb[0]) + SUM_W'(r_bb[1]) + SUM_W'(r_bb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_na <= s2_na[PROD_W-1:0];
            r_nb <= s2_nb[PROD_W-1:0];
            r_e  <= SUM_W'(r_ab[0]) + SUM_W'(r_ab[1]) + SUM_W'(r_ab[2]);
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= CRS_W'(r_xa[i]) - CRS_W'(r_xb[i]);
            end
        end
    end

    // ---------------- stage 3: wide squares, magnitudes ----------------
    logic [SUM_W-1:0]  s3_eabs;
    logic [CRS_W-1:0]  s3_cabs [3];
    logic [WIDE_W-1:0] r_pn;
    logic [WIDE_W-1:0] r_csq [3];
    t_side_p           r_s3;
    logic              r_v3;

    always_comb begin
        s3_eabs = r_e[SUM_W-1] ? SUM_W'(-r_e) : SUM_W'(r_e);
        for (int i = 0; i < 3; i++) begin
            s3_cabs[i] = r_c[i][CRS_W-1] ? CRS_W'(-r_c[i]) : CRS_W'(r_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pn <= WIDE_W'(r_na) * WIDE_W'(r_nb);
            for (int i = 0; i < 3; i++) begin
                r_csq[i]       <= WIDE_W'(r_c[i] * r_c[i]);
                r_s3.cmag[i]   <= s3_cabs[i][PROD_W-1:0];
                r_s3.cneg[i]   <= r_c[i][CRS_W-1];
            end
            r_s3.emag <= s3_eabs[PROD_W-1:0];
            r_s3.eneg <= r_e[SUM_W-1];
            r_s3.zero <= (r_na == '0) || (r_nb == '0);
        end
    end

    // ---------------- stage 4: cross product length squared ----------------
    logic [WIDE_W-1:0] r_pn4;
    logic [WIDE_W-1:0] r_csum;
    t_side_p           r_s4;
    logic              r_v4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pn4  <= r_pn;
            r_csum <= r_csq[0] + r_csq[1] + r_csq[2];
            r_s4   <= r_s3;
        end
    end

    // Track valid through the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // ---------------- roots of |a|^2 |b|^2 and |c|^2 ----------------
    logic              vld_p;
    logic              vld_c;
    logic [PROD_W-1:0] p_root;
    logic [PROD_W-1:0] c_root;
    t_side_p           side_p;
    logic [0:0]        side_c;

    vprq_isqrt_pipe #(
        .RAD_W  (WIDE_W),
        .SIDE_W ($bits(t_side_p))
    ) u_isqrt_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v4),
        .i_rad   (r_pn4),
        .i_side  (r_s4),
        .o_vld   (vld_p),
        .o_root  (p_root),
        .o_side  (side_p)
    );

    vprq_isqrt_pipe #(
        .RAD_W  (WIDE_W),
        .SIDE_W (1)
    ) u_isqrt_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v4),
        .i_rad   (r_csum),
        .i_side  (r_s4.zero),
        .o_vld   (vld_c),
        .o_root  (c_root),
        .o_side  (side_c)
    );

    // ---------------- normalized dot product ----------------
    t_side_d           d_side_in;
    t_side_d           d_side;
    logic              vld_d;
    logic [D_Q_W-1:0]  d_quot;

    always_comb begin
        d_side_in.eneg  = side_p.eneg;
        d_side_in.cnorm = c_root;
        d_side_in.cmag  = side_p.cmag;
        d_side_in.cneg  = side_p.cneg;
        d_side_in.zero  = side_p.zero | side_c[0];
    end

    vprq_div_pipe #(
        .NUM_W  (D_NUM_W),
        .DEN_W  (PROD_W),
        .Q_W    (D_Q_W),
        .SIDE_W ($bits(t_side_d))
    ) u_div_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (vld_p),
        .i_num   ({side_p.emag, Q30_BITS'(0)}),
        .i_den   (p_root),
        .i_side  (d_side_in),
        .o_vld   (vld_d),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    // ---------------- stage 5: clamp and sign ----------------
    logic [D_Q_W-1:0]        s5_dm;
    logic signed [D_Q_W:0]   r_d;
    t_side_d                 r_s5;
    logic                    r_v5;

    always_comb begin
        s5_dm = (d_quot > ONE_Q30) ? ONE_Q30 : d_quot;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d  <= d_side.eneg ? -$signed({1'b0, s5_dm}) : $signed({1'b0, s5_dm});
            r_s5 <= d_side;
        end
    end

    // ---------------- stage 6: classify, half-angle radicands ----------------
    t_case            s6_code;
    logic [D_Q_W:0]   s6_wa;
    logic [D_Q_W:0]   s6_sa;
    logic [HA_RAD_W-1:0] r_wrad;
    logic [HA_RAD_W-1:0] r_srad;
    t_side_w          r_s6;
    logic             r_v6;

    always_comb begin
        s6_wa = {1'b0, ONE_Q30} + $unsigned(r_d);
        s6_sa = {1'b0, ONE_Q30} - $unsigned(r_d);
        priority if (r_s5.zero) begin
            s6_code = CASE_ZERO;
        end else if (r_d > DOT_LIMIT || (r_s5.cnorm == '0 && !r_d[D_Q_W])) begin
            s6_code = CASE_ALIGNED;
        end else if (r_d < -DOT_LIMIT || r_s5.cnorm == '0) begin
            s6_code = CASE_OPPOSITE;
        end else begin
            s6_code = CASE_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wrad     <= {1'b0, s6_wa, (Q30_BITS - 1)'(0)};
            r_srad     <= {1'b0, s6_sa, (Q30_BITS - 1)'(0)};
            r_s6.code  <= s6_code;
            r_s6.cnorm <= r_s5.cnorm;
            r_s6.cmag  <= r_s5.cmag;
            r_s6.cneg  <= r_s5.cneg;
        end
    end

    // Track valid through the middle stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v5 <= vld_d;
            r_v6 <= r_v5;
        end
    end

    // ---------------- half-angle cosine and sine ----------------
    logic            vld_w;
    logic            vld_s;
    logic [HA_W-1:0] w30;
    logic [HA_W-1:0] s30;
    t_side_w         side_w;
    logic [0:0]      side_s;

    vprq_isqrt_pipe #(
        .RAD_W  (HA_RAD_W),
        .SIDE_W ($bits(t_side_w))
    ) u_isqrt_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v6),
        .i_rad   (r_wrad),
        .i_side  (r_s6),
        .o_vld   (vld_w),
        .o_root  (w30),
        .o_side  (side_w)
    );

    vprq_isqrt_pipe #(
        .RAD_W  (HA_RAD_W),
        .SIDE_W (1)
    ) u_isqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v6),
        .i_rad   (r_srad),
        .i_side  (1'b0),
        .o_vld   (vld_s),
        .o_root  (s30),
        .o_side  (side_s)
    );

    // ---------------- stage 7: axis products, round w ----------------
    logic [HA_W:0]         s7_wsum;
    logic [AX_PRD_W-1:0]   r_prod [3];
    logic [OUT_WIDTH-1:0]  r_wr;
    t_side_w               r_s7;
    logic                  r_v7;

    always_comb begin
        s7_wsum = (HA_W + 1)'(w30) + ((HA_W + 1)'(1) << (ROUND_SH - 1))
                + (HA_W + 1)'(side_s);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= AX_PRD_W'(side_w.cmag[i]) * AX_PRD_W'(s30);
            end
            r_wr <= s7_wsum[ROUND_SH +: OUT_WIDTH];
            r_s7 <= side_w;
        end
    end

    // ---------------- stage 8: add half divisor, drop the shift ----------------
    logic [WIDE_W-1:0]   s8_sum [3];
    logic [AX_NUM_W-1:0] r_num [3];
    t_side_x             r_s8;
    logic                r_v8;
    logic [PROD_W-1:0]   r_cnorm8;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s8_sum[i] = WIDE_W'(r_prod[i]) + (WIDE_W'(r_s7.cnorm) << (ROUND_SH - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= s8_sum[i][WIDE_W-1:ROUND_SH];
            end
            r_s8.code <= r_s7.code;
            r_s8.wr   <= r_wr;
            r_s8.cneg <= r_s7.cneg;
        end
    end

    // Divisor aligned with the stage 8 numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cnorm8 <= r_s7.cnorm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v7 <= vld_w;
            r_v8 <= r_v7;
        end
    end

    // ---------------- axis dividers ----------------
    logic              vld_x [3];
    logic [AX_Q_W-1:0] q_ax  [3];
    t_side_x           side_x;
    logic [0:0]        side_x1;
    logic [0:0]        side_x2;

    vprq_div_pipe #(
        .NUM_W  (AX_NUM_W),
        .DEN_W  (PROD_W),
        .Q_W    (AX_Q_W),
        .SIDE_W ($bits(t_side_x))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v8),
        .i_num   (r_num[0]),
        .i_den   (r_cnorm8),
        .i_side  (r_s8),
        .o_vld   (vld_x[0]),
        .o_quot  (q_ax[0]),
        .o_side  (side_x)
    );

    vprq_div_pipe #(
        .NUM_W  (AX_NUM_W),
        .DEN_W  (PROD_W),
        .Q_W    (AX_Q_W),
        .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v8),
        .i_num   (r_num[1]),
        .i_den   (r_cnorm8),
        .i_side  (1'b0),
        .o_vld   (vld_x[1]),
        .o_quot  (q_ax[1]),
        .o_side  (side_x1)
    );

    vprq_div_pipe #(
        .NUM_W  (AX_NUM_W),
        .DEN_W  (PROD_W),
        .Q_W    (AX_Q_W),
        .SIDE_W (1)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v8),
        .i_num   (r_num[2]),
        .i_den   (r_cnorm8),
        .i_side  (1'b0),
        .o_vld   (vld_x[2]),
        .o_quot  (q_ax[2]),
        .o_side  (side_x2)
    );

    // ---------------- stage 9: assemble result ----------------
    logic signed [OUT_WIDTH-1:0] s9_q [3];
    t_quat                       s9_out;
    t_quat                       r_out;
    logic                        r_out_vld;
    t_quat                       r_skid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s9_q[i] = side_x.cneg[i] ? -$signed(OUT_WIDTH'(q_ax[i]))
                                     : $signed(OUT_WIDTH'(q_ax[i]));
        end
        s9_out.quat_w    = ONE_OUT;
        s9_out.quat_x    = '0;
        s9_out.quat_y    = '0;
        s9_out.quat_z    = '0;
        s9_out.case_code = side_x.code;
        unique case (side_x.code)
            CASE_GENERAL: begin
                s9_out.quat_w = $signed(side_x.wr) ^ OUT_WIDTH'(side_x1 ^ side_x2);
                s9_out.quat_x = s9_q[0];
                s9_out.quat_y = s9_q[1];
                s9_out.quat_z = s9_q[2];
            end
            CASE_OPPOSITE: begin
                s9_out.quat_w = '0;
                s9_out.quat_z = ONE_OUT;
            end
            CASE_ALIGNED, CASE_ZERO: begin
                s9_out.quat_w = ONE_OUT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vld_x[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= s9_out;
        end
    end

    // Park the output beat when the consumer stalls, release it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (i_out_ready) begin
                r_skid_full <= 1'b0;
            end
        end else if (r_out_vld && !i_out_ready) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full) begin
            r_skid <= r_out;
        end
    end

    assign o_out_valid = r_skid_full | r_out_vld;
    assign o_out_data  = r_skid_full ? r_skid : r_out;

    // ---------------- assertions ----------------
    a_root_lanes_agree : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld_p == vld_c) && (vld_w == vld_s))
        else $error("parallel root lanes lost alignment");

    a_div_lanes_agree : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld_x[0] == vld_x[1]) && (vld_x[0] == vld_x[2]))
        else $error("axis divider lanes lost alignment");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid filled without a stalled output beat");

    a_frozen_on_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |=> $stable(r_out_vld) && $stable(r_out))
        else $error("pipeline moved while a beat was parked");

    a_w_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.case_code == CASE_GENERAL) |->
            (o_out_data.quat_w <= ONE_OUT) && (o_out_data.quat_w >= 0))
        else $error("general case w out of range");

endmodule

`default_nettype wire

[rtl/vprq_isqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, with a sideband.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vprq_isqrt_pipe #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_vld,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [RAD_W-1:0]  r_rad  [ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic              r_vld  [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_stage
            logic [RAD_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SIDE_W-1:0] side_in;
            logic              vld_in;
            logic [REM_W+1:0]  rem_sh;
            logic [REM_W+1:0]  trial;
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;

            if (g == 0) begin : g_head
                assign rad_in  = i_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = i_side;
                assign vld_in  = i_vld;
            end else begin : g_body
                assign rad_in  = r_rad[g-1];
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
                assign side_in = r_side[g-1];
                assign vld_in  = r_vld[g-1];
            end

            // Bring down two radicand bits and try the next root bit
            always_comb begin
                rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial) begin
                    n_rem  = REM_W'(rem_sh - trial);
                    n_root = {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(rem_sh);
                    n_root = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_root[g] <= n_root;
                    r_side[g] <= side_in;
                end
            end

            // Last stage keeps no radicand or remainder
            if (g < ROOT_W - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rad[g] <= {rad_in[RAD_W-3:0], 2'b00};
                        r_rem[g] <= n_rem;
                    end
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/vprq_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Expects the dividend below the divisor shifted by the quotient width.
// Generic; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vprq_div_pipe #(
    parameter int NUM_W  = 62,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quot,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [NUM_W-1:0]  r_rem  [Q_W-1];
    logic [DEN_W-1:0]  r_den  [Q_W-1];
    logic [Q_W-1:0]    r_quot [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic              r_vld  [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            localparam int K = Q_W - 1 - g;
            logic [NUM_W-1:0]  rem_in;
            logic [DEN_W-1:0]  den_in;
            logic [Q_W-1:0]    quot_in;
            logic [SIDE_W-1:0] side_in;
            logic              vld_in;
            logic [CMP_W-1:0]  rem_ext;
            logic [CMP_W-1:0]  shd;
            logic [NUM_W-1:0]  n_rem;
            logic [Q_W-1:0]    n_quot;

            if (g == 0) begin : g_head
                assign rem_in  = i_num;
                assign den_in  = i_den;
                assign quot_in = '0;
                assign side_in = i_side;
                assign vld_in  = i_vld;
            end else begin : g_body
                assign rem_in  = r_rem[g-1];
                assign den_in  = r_den[g-1];
                assign quot_in = r_quot[g-1];
                assign side_in = r_side[g-1];
                assign vld_in  = r_vld[g-1];
            end

            // Subtract the shifted divisor when it fits
            always_comb begin
                rem_ext = CMP_W'(rem_in);
                shd     = CMP_W'(den_in) << K;
                n_quot  = quot_in;
                if (rem_ext >= shd) begin
                    n_rem     = NUM_W'(rem_ext - shd);
                    n_quot[K] = 1'b1;
                end else begin
                    n_rem     = rem_in;
                    n_quot[K] = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quot[g] <= n_quot;
                    r_side[g] <= side_in;
                end
            end

            if (g < Q_W - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[g] <= n_rem;
                        r_den[g] <= den_in;
                    end
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[Q_W-1];
    assign o_quot = r_quot[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for vector_pair_rotation_quaternion: directed and random vector pairs,
// with results checked against a shortest-arc quaternion predictor.
// Depends on vprq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import vprq_pkg::*;

    // Holds predicted quaternions in arrival order and checks each result beat
    class quat_scoreboard;
        t_quat pending_quats[$];
        int    mismatch_cnt;

        // Integer square root, floor
        static function longint unsigned isqrt64(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        static function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        // Shortest-arc quaternion; at 16-bit inputs no range reduction is needed
        static function t_quat rotation_of(t_vec_pair pr);
            longint          va[3], vb[3], cr[3];
            longint          e, d, one30;
            longint unsigned na, nb, pn, dm, csq, cn, w30, s30, den, m;
            t_quat           q;
            one30 = 64'sd1 << Q30_BITS;
            va[0] = pr.start_x;  va[1] = pr.start_y;  va[2] = pr.start_z;
            vb[0] = pr.target_x; vb[1] = pr.target_y; vb[2] = pr.target_z;
            q.quat_w = ONE_OUT;
            q.quat_x = '0;
            q.quat_y = '0;
            q.quat_z = '0;
            na = va[0] * va[0] + va[1] * va[1] + va[2] * va[2];
            nb = vb[0] * vb[0] + vb[1] * vb[1] + vb[2] * vb[2];
            if (na == 0 || nb == 0) begin
                q.case_code = CASE_ZERO;
                return q;
            end
            e  = va[0] * vb[0] + va[1] * vb[1] + va[2] * vb[2];
            pn = isqrt64(na * nb);
            dm = (mag(e) << Q30_BITS) / pn;
            if (dm > one30) dm = one30;
            d = (e < 0) ? -longint'(dm) : longint'(dm);
            cr[0] = va[1] * vb[2] - va[2] * vb[1];
            cr[1] = va[2] * vb[0] - va[0] * vb[2];
            cr[2] = va[0] * vb[1] - va[1] * vb[0];
            csq = 0;
            for (int i = 0; i < 3; i++) csq += mag(cr[i]) * mag(cr[i]);
            cn = isqrt64(csq);
            if (d > longint'(DOT_LIMIT) || (cn == 0 && d >= 0)) begin
                q.case_code = CASE_ALIGNED;
                return q;
            end
            if (d < -longint'(DOT_LIMIT) || cn == 0) begin
                q.quat_w    = '0;
                q.quat_z    = ONE_OUT;
                q.case_code = CASE_OPPOSITE;
                return q;
            end
            w30 = isqrt64(longint'(one30 + d) << 29);
            s30 = isqrt64(longint'(one30 - d) << 29);
            den = cn << ROUND_SH;
            q.quat_w = OUT_WIDTH'((w30 + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH);
            for (int i = 0; i < 3; i++) begin
                m = (mag(cr[i]) * s30 + den / 2) / den;
                if (cr[i] < 0) m = -m;
                case (i)
                    0: q.quat_x = OUT_WIDTH'(m);
                    1: q.quat_y = OUT_WIDTH'(m);
                    default: q.quat_z = OUT_WIDTH'(m);
                endcase
            end
            q.case_code = CASE_GENERAL;
            return q;
        endfunction

        function void note_pair(t_vec_pair pr);
            pending_quats.push_back(rotation_of(pr));
        endfunction

        function void check_quat(t_quat got);
            t_quat want;
            if (pending_quats.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("ERROR: unexpected result beat %p", got);
                return;
            end
            want = pending_quats.pop_front();
            if (got.quat_w !== want.quat_w || got.quat_x !== want.quat_x ||
                got.quat_y !== want.quat_y || got.quat_z !== want.quat_z ||
                got.case_code !== want.case_code) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $write("ERROR: expected w=%0d x=%0d y=%0d z=%0d case=%s, ",
                           want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                           want.case_code.name());
                    $display("got w=%0d x=%0d y=%0d z=%0d case=%0d",
                             got.quat_w, got.quat_x, got.quat_y, got.quat_z,
                             got.case_code);
                end
            end
        endfunction
    endclass

    localparam int NUM_RANDOM  = 1650;
    localparam int QUIET_TAIL  = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_vec_pair in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_quat     out_data;

    bit             quiet_phase = 1'b0;
    int             cycle_cnt = 0;
    int             stall_left = 0;
    quat_scoreboard quat_sb = new();

    vector_pair_rotation_quaternion i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check result beats and stall the output in random bursts
    always @(posedge i_clk) begin
        int next_stall;
        next_stall = stall_left;
        if (i_rst_n && out_valid && out_ready) quat_sb.check_quat(out_data);
        if (next_stall > 0) begin
            next_stall--;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            next_stall = $urandom_range(1, 5);
        end
        stall_left <= next_stall;
        out_ready  <= i_rst_n && (next_stall == 0);
    end

    // Drive one input beat, with an optional idle burst first
    task automatic send_pair(t_vec_pair pr);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= pr;
        do @(posedge i_clk); while (!in_ready);
        quat_sb.note_pair(pr);
    endtask

    task automatic send_vecs(int ax, int ay, int az, int bx, int by, int bz);
        t_vec_pair pr;
        pr.start_x  = IN_WIDTH'(ax);
        pr.start_y  = IN_WIDTH'(ay);
        pr.start_z  = IN_WIDTH'(az);
        pr.target_x = IN_WIDTH'(bx);
        pr.target_y = IN_WIDTH'(by);
        pr.target_z = IN_WIDTH'(bz);
        send_pair(pr);
    endtask

    function automatic int rnd_signed(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // Random pair: raw, (near-)parallel or opposite, tiny, zero-start or free-target
    task automatic send_random_pair();
        int ax, ay, az, k, sgn;
        ax = rnd_signed(10000);
        ay = rnd_signed(10000);
        az = rnd_signed(10000);
        k  = $urandom_range(1, 3);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 9))
            0, 1, 2: send_pair(t_vec_pair'({$urandom, $urandom, $urandom}));
            3, 4: send_vecs(ax, ay, az, sgn * k * ax + rnd_signed(2),
                            sgn * k * ay + rnd_signed(2), sgn * k * az + rnd_signed(2));
            5: send_vecs(ax, ay, az, sgn * k * ax, sgn * k * ay, sgn * k * az);
            6: send_vecs(rnd_signed(4), rnd_signed(4), rnd_signed(4),
                         rnd_signed(4), rnd_signed(4), rnd_signed(4));
            7: send_vecs(0, 0, 0, rnd_signed(32767), ay, az);
            default: send_vecs(ax, ay, az, rnd_signed(32767), rnd_signed(32767),
                               rnd_signed(32767));
        endcase
    endtask

    initial begin
        int drain;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vectors, extremes, aligned, opposite, orthogonal, near-parallel
        send_vecs(0, 0, 0, 0, 0, 0);
        send_vecs(0, 0, 0, 256, 0, 0);
        send_vecs(256, 0, 0, 0, 0, 0);
        send_vecs(256, 0, 0, 256, 0, 0);
        send_vecs(256, 0, 0, 512, 0, 0);
        send_vecs(256, 0, 0, -256, 0, 0);
        send_vecs(0, 0, 256, 0, 0, -256);
        send_vecs(256, 0, 0, 0, 256, 0);
        send_vecs(0, 256, 0, 0, 0, 256);
        send_vecs(0, 0, 256, 256, 0, 0);
        send_vecs(-32768, -32768, -32768, -32768, -32768, -32768);
        send_vecs(-32768, -32768, -32768, 32767, 32767, 32767);
        send_vecs(32767, 32767, 32767, 32767, 32767, 32767);
        send_vecs(-32768, 0, 0, 0, 32767, 0);
        send_vecs(32767, -32768, 1, -1, 32767, -32768);
        send_vecs(1, 0, 0, 0, 0, 1);
        send_vecs(1, 1, 1, -1, -1, -1);
        send_vecs(30000, 1, 0, 30000, 0, 0);
        send_vecs(30000, 1, 0, -30000, 0, 0);
        send_vecs(10000, 10, 0, 10000, 0, 0);
        send_vecs(256, 256, 0, -256, 256, 1);
        send_vecs(-1, 0, 0, 1, 0, 0);

        // Hold input until the pipeline has drained
        in_valid <= 1'b0;
        while (quat_sb.pending_quats.size() != 0) @(posedge i_clk);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - QUIET_TAIL) quiet_phase = 1'b1;
            send_random_pair();
        end
        in_valid <= 1'b0;

        // Drain and let the pipeline settle
        while (quat_sb.pending_quats.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < DRAIN_WAIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (quat_sb.mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/vprq_pkg.sv
rtl/vprq_isqrt_pipe.sv
rtl/vprq_div_pipe.sv
rtl/vector_pair_rotation_quaternion.sv
bench/tb_top.sv
